// File: hw/rtl/tga_stream_decoder_top_defines.svh
// Assertion macros for the TGA stream decoder checker.
// No dependencies; included by the files that assert.
`ifndef TGA_STREAM_DECODER_TOP_DEFINES_SVH
`define TGA_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TGA_SD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tga_sd: implication failed");

// Next-cycle implication, off during reset.
`define TGA_SD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tga_sd: next-cycle implication failed");

// Next-cycle implication that also holds through reset.
`define TGA_SD_ASSERT_NEXT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tga_sd: reset implication failed");

`endif

// File: hw/rtl/tga_sd_pkg.sv
// Shared types, codes and colour decoding for the TGA stream decoder.
// No dependencies; used by every RTL file of the block.
package tga_sd_pkg;

   localparam int MAP_ENTRIES_DEF = 256;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BYTE  = 2'd1;
   localparam logic [1:0] ACT_DRAIN = 2'd2;

   localparam logic CSR_MATCH_WIDTH  = 1'b0;
   localparam logic CSR_MATCH_HEIGHT = 1'b1;

   localparam logic [7:0] KIND_MAP     = 8'd1;
   localparam logic [7:0] KIND_TRUE    = 8'd2;
   localparam logic [7:0] KIND_GREY    = 8'd3;
   localparam logic [7:0] KIND_RLE_MAP = 8'd9;
   localparam logic [7:0] KIND_RLE_TRUE = 8'd10;
   localparam logic [7:0] KIND_RLE_GREY = 8'd11;

   localparam logic [7:0] DEPTH_8  = 8'd8;
   localparam logic [7:0] DEPTH_15 = 8'd15;
   localparam logic [7:0] DEPTH_16 = 8'd16;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   localparam logic [15:0] HEAD_LAST  = 16'd17;
   localparam logic [17:0] MAP_LIMIT  = 18'd16384;

   typedef enum logic [2:0] {
      ST_HEADER_OK,
      ST_PIXEL,
      ST_SIZE_MISMATCH,
      ST_BAD_TYPE,
      ST_BAD_DEPTH,
      ST_BAD_MAP_DEPTH,
      ST_MAP_TOO_BIG,
      ST_RUN_BYTE
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEAD,
      PH_ID,
      PH_MAP,
      PH_BODY,
      PH_DRAIN,
      PH_DONE
   } phase_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] row;
      logic [15:0] column;
      logic [31:0] colour;
      logic        last;
      logic        pending;
      logic        use_map;
      logic        hit;
      logic        use_run;
      logic        capture;
      logic [15:0] slot;
   } result_type;

   typedef struct packed {
      logic        en;
      logic [15:0] addr;
      logic [31:0] data;
   } palette_wr_type;

   function automatic logic depth_ok(input logic [7:0] d);
      return d == DEPTH_8 || d == DEPTH_15 || d == DEPTH_16 ||
             d == DEPTH_24 || d == DEPTH_32;
   endfunction

   // Colour words are packed red in the low byte, alpha in the high byte.
   function automatic logic [31:0] decode_colour(input logic [31:0] v,
                                                 input logic [7:0] depth);
      logic [7:0] j;
      logic [7:0] k;
      logic [7:0] a;
      j = v[7:0];
      k = v[15:8];
      a = (depth == DEPTH_15 || k[7]) ? 8'hFF : 8'h00;
      case (depth)
         DEPTH_8:  return {8'hFF, j, j, j};
         DEPTH_15, DEPTH_16:
            return {a, j[4:0], 3'b000, k[1:0], j[7:5], 3'b000, k[6:2], 3'b000};
         DEPTH_24: return {8'hFF, j, k, v[23:16]};
         DEPTH_32: return {v[31:24], j, k, v[23:16]};
         default:  return 32'd0;
      endcase
   endfunction

endpackage

// File: hw/rtl/tga_stream_decoder_top.sv
// Top level of the TGA stream decoder: parser plus palette and output stage.
// Depends on tga_sd_pkg, tga_sd_parse and tga_sd_out.
//
//   channel  direction  handshake              carries
//   req      in         req_tvalid/req_tready  action (tuser), file byte (tdata)
//   rsp      out        rsp_tvalid/rsp_tready  status (tuser), last pixel (tlast), rest
//   csr      in         csr_we                 match width / match height
//
// One item per cycle while req_tready is high; a result passes through the palette read
// stage, then the output register. Synchronous reset clears control state; the
// palette holds garbage until a file loads it. A stalled rsp side fills the
// lookup stage, then req_tready drops.
module tga_stream_decoder_top #(
   parameter int MAP_ENTRIES = tga_sd_pkg::MAP_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // in_byte
   input  logic [1:0]   req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // frame width, frame height, row, column,
                                     // red, green, blue, alpha, run_pending, zero fill
   output logic         rsp_tlast,   // last_pixel
   output logic [2:0]   rsp_tuser,   // status
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   tga_sd_pkg::result_type     res;
   tga_sd_pkg::palette_wr_type wr;
   logic res_valid;

   tga_sd_parse #(.MAP_ENTRIES(MAP_ENTRIES)) u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && req_tready),
      .in_action (req_tuser),
      .in_byte   (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .res_valid (res_valid),
      .res       (res),
      .wr        (wr)
   );

   tga_sd_out #(.MAP_ENTRIES(MAP_ENTRIES)) u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .wr         (wr),
      .take       (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hw/rtl/tga_sd_parse.sv
// Header, ID, colour map and body parser of the TGA stream decoder.
// Depends on tga_sd_pkg; feeds tga_sd_out with results and palette writes.
module tga_sd_parse #(
   parameter int MAP_ENTRIES = tga_sd_pkg::MAP_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [1:0]                 in_action,
   input  logic [7:0]                 in_byte,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [15:0]                csr_wdata,
   output logic                       res_valid,
   output tga_sd_pkg::result_type     res,
   output tga_sd_pkg::palette_wr_type wr
);

   localparam logic [16:0] ENTRIES = 17'(MAP_ENTRIES);

   tga_sd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] match_w_ff, match_h_ff;
   logic [15:0] fbc_ff, fbc_in;
   logic [7:0]  kind_ff, kind_in, pdepth_ff, pdepth_in, mdepth_ff, mdepth_in;
   logic        mpres_ff, mpres_in;
   logic [15:0] mfirst_ff, mfirst_in, mlen_ff, mlen_in;
   logic [7:0]  idskip_ff, idskip_in, attr_ff, attr_in;
   logic [15:0] width_ff, width_in, height_ff, height_in;
   logic [31:0] part_ff, part_in;
   logic [5:0]  sub_ff, sub_in;
   logic [7:0]  rleft_ff, rleft_in;
   logic        rrep_ff, rrep_in;
   logic [15:0] col_ff, col_in, rows_ff, rows_in, frow_ff, frow_in, prow_ff, prow_in;

   logic mapped, rle, act_start, act_byte, act_drain;
   logic [31:0] part_n;
   logic [5:0]  sub_n, ebytes, pbytes;
   logic [8:0]  ebytes_sum, pbytes_sum;
   logic [16:0] fbc_inc, col_inc, rows_inc, frow_sum;
   logic [2:0]  step;
   logic        wrap, done, last;
   logic [15:0] row_out, col_nx, rows_nx, frow_nx, prow_nx;
   logic        head_end, body_hdr, body_pix, drain_pix, drain_byte;
   tga_sd_pkg::status_type head_st;
   tga_sd_pkg::phase_type  body_phase, aid_phase;
   logic        map_go, capture, pend;
   logic [7:0]  rl_body, rl_drain;
   logic [15:0] idx, slot;
   logic [17:0] map_sum;

   assign mapped = mpres_ff && (kind_ff == tga_sd_pkg::KIND_MAP ||
                                kind_ff == tga_sd_pkg::KIND_RLE_MAP);
   assign rle = kind_ff == tga_sd_pkg::KIND_RLE_MAP ||
                kind_ff == tga_sd_pkg::KIND_RLE_TRUE ||
                kind_ff == tga_sd_pkg::KIND_RLE_GREY;
   assign act_start = in_valid && in_action == tga_sd_pkg::ACT_START;
   assign act_byte  = in_valid && in_action == tga_sd_pkg::ACT_BYTE;
   assign act_drain = in_valid && in_action == tga_sd_pkg::ACT_DRAIN &&
                      phase_ff == tga_sd_pkg::PH_DRAIN;

   always_comb begin
      part_n = part_ff;
      if (sub_ff < 6'd4) begin
         case (sub_ff[1:0])
            2'd0:    part_n[7:0]   = part_ff[7:0]   | in_byte;
            2'd1:    part_n[15:8]  = part_ff[15:8]  | in_byte;
            2'd2:    part_n[23:16] = part_ff[23:16] | in_byte;
            default: part_n[31:24] = part_ff[31:24] | in_byte;
         endcase
      end
   end

   assign sub_n      = sub_ff + 6'd1;
   assign ebytes_sum = {1'b0, mdepth_ff} + 9'd7;
   assign pbytes_sum = {1'b0, pdepth_ff} + 9'd7;
   assign ebytes     = ebytes_sum[8:3];
   assign pbytes     = pbytes_sum[8:3];
   assign fbc_inc    = {1'b0, fbc_ff} + 17'd1;

   // Pixel position bookkeeping, shared by body pixels and drain ticks.
   assign row_out  = attr_ff[5] ? frow_ff : height_ff - frow_ff - 16'd1;
   assign col_inc  = {1'b0, col_ff} + 17'd1;
   assign rows_inc = {1'b0, rows_ff} + 17'd1;
   assign step     = (attr_ff[7:6] == 2'd2) ? 3'd4 : (attr_ff[7:6] == 2'd1) ? 3'd2 : 3'd1;
   assign frow_sum = {1'b0, frow_ff} + {14'd0, step};
   assign wrap     = col_inc >= {1'b0, width_ff};
   assign last     = rows_inc == {1'b0, height_ff} && col_inc == {1'b0, width_ff};
   assign prow_nx  = (wrap && frow_sum >= {1'b0, height_ff}) ? prow_ff + 16'd1 : prow_ff;
   assign col_nx   = wrap ? 16'd0 : col_inc[15:0];
   assign rows_nx  = wrap ? rows_inc[15:0] : rows_ff;
   assign frow_nx  = !wrap ? frow_ff :
                     (frow_sum >= {1'b0, height_ff}) ? prow_nx : frow_sum[15:0];
   assign done     = wrap ? rows_inc >= {1'b0, height_ff} : rows_ff >= height_ff;

   assign map_sum = {2'd0, mfirst_ff} + {2'd0, mlen_ff} + 18'd1;
   always_comb begin
      if ((match_w_ff != 16'd0 && width_ff != match_w_ff) ||
          (match_h_ff != 16'd0 && height_ff != match_h_ff))
         head_st = tga_sd_pkg::ST_SIZE_MISMATCH;
      else if (!(kind_ff == tga_sd_pkg::KIND_MAP || kind_ff == tga_sd_pkg::KIND_TRUE ||
                 kind_ff == tga_sd_pkg::KIND_GREY || rle))
         head_st = tga_sd_pkg::ST_BAD_TYPE;
      else if (!tga_sd_pkg::depth_ok(pdepth_ff))
         head_st = tga_sd_pkg::ST_BAD_DEPTH;
      else if (mapped && !tga_sd_pkg::depth_ok(mdepth_ff))
         head_st = tga_sd_pkg::ST_BAD_MAP_DEPTH;
      else if (mapped && (map_sum >= tga_sd_pkg::MAP_LIMIT || {1'b0, mlen_ff} > ENTRIES))
         head_st = tga_sd_pkg::ST_MAP_TOO_BIG;
      else
         head_st = tga_sd_pkg::ST_HEADER_OK;
   end

   assign body_phase = (width_ff == 16'd0 || height_ff == 16'd0) ?
                       tga_sd_pkg::PH_DONE : tga_sd_pkg::PH_BODY;
   assign map_go     = mpres_ff && mlen_ff != 16'd0 && ebytes != 6'd0;
   assign aid_phase  = map_go ? tga_sd_pkg::PH_MAP : body_phase;

   assign head_end   = act_byte && phase_ff == tga_sd_pkg::PH_HEAD && fbc_ff == tga_sd_pkg::HEAD_LAST;
   assign body_hdr   = act_byte && phase_ff == tga_sd_pkg::PH_BODY && rle && rleft_ff == 8'd0;
   assign body_pix   = act_byte && phase_ff == tga_sd_pkg::PH_BODY && !body_hdr &&
                       sub_n >= pbytes;
   assign drain_pix  = act_drain;
   assign drain_byte = act_byte && phase_ff == tga_sd_pkg::PH_DRAIN;

   assign rl_body  = (rle && rleft_ff != 8'd0) ? rleft_ff - 8'd1 : rleft_ff;
   assign rl_drain = (rleft_ff != 8'd0) ? rleft_ff - 8'd1 : rleft_ff;
   assign capture  = body_pix && rle && rrep_ff && rl_body != 8'd0;
   assign pend     = !done && (drain_pix ? rl_drain != 8'd0 : capture);

   always_comb begin
      if (pdepth_ff == tga_sd_pkg::DEPTH_8)
         idx = {8'd0, part_n[7:0]};
      else if (pdepth_ff == tga_sd_pkg::DEPTH_15 || pdepth_ff == tga_sd_pkg::DEPTH_16)
         idx = part_n[15:0];
      else
         idx = 16'd0;
   end
   assign slot = idx - mfirst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_w_ff <= 16'd0;
         match_h_ff <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            tga_sd_pkg::CSR_MATCH_WIDTH:  match_w_ff <= csr_wdata;
            tga_sd_pkg::CSR_MATCH_HEIGHT: match_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;   fbc_in = fbc_ff;       kind_in = kind_ff;
      pdepth_in = pdepth_ff; mdepth_in = mdepth_ff; mpres_in = mpres_ff;
      mfirst_in = mfirst_ff; mlen_in = mlen_ff;     idskip_in = idskip_ff;
      attr_in = attr_ff;     width_in = width_ff;   height_in = height_ff;
      part_in = part_ff;     sub_in = sub_ff;       rleft_in = rleft_ff;
      rrep_in = rrep_ff;     col_in = col_ff;       rows_in = rows_ff;
      frow_in = frow_ff;     prow_in = prow_ff;
      if (act_start) begin
         phase_in = tga_sd_pkg::PH_HEAD;
         fbc_in = 16'd0;   kind_in = 8'd0;   pdepth_in = 8'd0; mpres_in = 1'b0;
         mfirst_in = 16'd0; mlen_in = 16'd0; mdepth_in = 8'd0; idskip_in = 8'd0;
         width_in = 16'd0; height_in = 16'd0; attr_in = 8'd0;  part_in = 32'd0;
         rleft_in = 8'd0;  rrep_in = 1'b0;   col_in = 16'd0;   rows_in = 16'd0;
         frow_in = 16'd0;  prow_in = 16'd0;  sub_in = 6'd0;
      end else if (drain_pix) begin
         rleft_in = rl_drain;
         phase_in = (rl_drain == 8'd0) ? tga_sd_pkg::PH_BODY : tga_sd_pkg::PH_DRAIN;
         col_in = col_nx; rows_in = rows_nx; frow_in = frow_nx; prow_in = prow_nx;
         if (done) begin
            phase_in = tga_sd_pkg::PH_DONE;
            rleft_in = 8'd0;
            rrep_in  = 1'b0;
         end
      end else if (act_byte) begin
         case (phase_ff)
            tga_sd_pkg::PH_HEAD: begin
               case (fbc_ff[4:0])
                  5'd0:  idskip_in = in_byte;
                  5'd1:  mpres_in = in_byte == 8'd1;
                  5'd2:  kind_in = in_byte;
                  5'd3:  mfirst_in = {8'd0, in_byte};
                  5'd4:  mfirst_in[15:8] = mfirst_ff[15:8] | in_byte;
                  5'd5:  mlen_in = {8'd0, in_byte};
                  5'd6:  mlen_in[15:8] = mlen_ff[15:8] | in_byte;
                  5'd7:  mdepth_in = in_byte;
                  5'd12: width_in = {8'd0, in_byte};
                  5'd13: width_in[15:8] = width_ff[15:8] | in_byte;
                  5'd14: height_in = {8'd0, in_byte};
                  5'd15: height_in[15:8] = height_ff[15:8] | in_byte;
                  5'd16: pdepth_in = in_byte;
                  5'd17: attr_in = in_byte;
                  default: ;
               endcase
               fbc_in = fbc_inc[15:0];
               if (head_end) begin
                  if (head_st != tga_sd_pkg::ST_HEADER_OK) begin
                     phase_in = tga_sd_pkg::PH_IDLE;
                  end else if (idskip_ff != 8'd0) begin
                     fbc_in = 16'd0;
                     phase_in = tga_sd_pkg::PH_ID;
                  end else begin
                     fbc_in = 16'd0; sub_in = 6'd0; part_in = 32'd0;
                     phase_in = aid_phase;
                  end
               end
            end
            tga_sd_pkg::PH_ID: begin
               fbc_in = fbc_inc[15:0];
               if (fbc_inc >= {9'd0, idskip_ff}) begin
                  fbc_in = 16'd0; sub_in = 6'd0; part_in = 32'd0;
                  phase_in = aid_phase;
               end
            end
            tga_sd_pkg::PH_MAP: begin
               part_in = part_n;
               sub_in = sub_n;
               if (sub_n >= ebytes) begin
                  fbc_in = fbc_inc[15:0];
                  sub_in = 6'd0;
                  part_in = 32'd0;
                  if (fbc_inc >= {1'b0, mlen_ff})
                     phase_in = body_phase;
               end
            end
            tga_sd_pkg::PH_BODY: begin
               if (body_hdr) begin
                  rrep_in = in_byte[7];
                  rleft_in = {1'b0, in_byte[6:0]} + 8'd1;
                  sub_in = 6'd0;
                  part_in = 32'd0;
               end else if (body_pix) begin
                  sub_in = 6'd0;
                  part_in = 32'd0;
                  rleft_in = rl_body;
                  if (capture)
                     phase_in = tga_sd_pkg::PH_DRAIN;
                  col_in = col_nx; rows_in = rows_nx; frow_in = frow_nx; prow_in = prow_nx;
                  if (done) begin
                     phase_in = tga_sd_pkg::PH_DONE;
                     rleft_in = 8'd0;
                     rrep_in  = 1'b0;
                  end
               end else begin
                  part_in = part_n;
                  sub_in = sub_n;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      res_valid   = head_end || body_pix || drain_pix || drain_byte;
      res         = '0;
      res.width   = width_ff;
      res.height  = height_ff;
      res.slot    = slot;
      if (head_end) begin
         res.status = head_st;
      end else if (drain_byte) begin
         res.status  = tga_sd_pkg::ST_RUN_BYTE;
         res.pending = 1'b1;
      end else if (body_pix || drain_pix) begin
         res.status  = tga_sd_pkg::ST_PIXEL;
         res.row     = row_out;
         res.column  = col_ff;
         res.last    = last;
         res.pending = pend;
         res.use_run = drain_pix;
         res.capture = capture;
         res.use_map = body_pix && mapped;
         res.hit     = slot < mlen_ff && {1'b0, slot} < ENTRIES;
         res.colour  = tga_sd_pkg::decode_colour(part_n, pdepth_ff);
      end
   end

   always_comb begin
      wr.en   = act_byte && phase_ff == tga_sd_pkg::PH_MAP && sub_n >= ebytes &&
                mapped && {1'b0, fbc_ff} < ENTRIES;
      wr.addr = fbc_ff;
      wr.data = tga_sd_pkg::decode_colour(part_n, mdepth_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tga_sd_pkg::PH_IDLE;
         fbc_ff <= '0;   kind_ff <= '0;   pdepth_ff <= '0; mdepth_ff <= '0;
         mpres_ff <= '0; mfirst_ff <= '0; mlen_ff <= '0;   idskip_ff <= '0;
         attr_ff <= '0;  width_ff <= '0;  height_ff <= '0; part_ff <= '0;
         sub_ff <= '0;   rleft_ff <= '0;  rrep_ff <= '0;   col_ff <= '0;
         rows_ff <= '0;  frow_ff <= '0;   prow_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         fbc_ff <= fbc_in;     kind_ff <= kind_in;     pdepth_ff <= pdepth_in;
         mdepth_ff <= mdepth_in; mpres_ff <= mpres_in; mfirst_ff <= mfirst_in;
         mlen_ff <= mlen_in;   idskip_ff <= idskip_in; attr_ff <= attr_in;
         width_ff <= width_in; height_ff <= height_in; part_ff <= part_in;
         sub_ff <= sub_in;     rleft_ff <= rleft_in;   rrep_ff <= rrep_in;
         col_ff <= col_in;     rows_ff <= rows_in;     frow_ff <= frow_in;
         prow_ff <= prow_in;
      end
   end

endmodule

// File: hw/rtl/tga_sd_out.sv
// Palette memory, lookup stage and output register of the TGA stream decoder.
// Depends on tga_sd_pkg; takes results and palette writes from tga_sd_parse.
module tga_sd_out #(
   parameter int MAP_ENTRIES = tga_sd_pkg::MAP_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       res_valid,
   input  tga_sd_pkg::result_type     res,
   input  tga_sd_pkg::palette_wr_type wr,
   output logic                       take,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [103:0]               rsp_tdata,
   output logic                       rsp_tlast,
   output logic [2:0]                 rsp_tuser
);

   localparam int AW = $clog2(MAP_ENTRIES);

   logic [31:0] palette [MAP_ENTRIES];
   logic        p_valid_ff, p_valid_in, o_valid_ff, o_valid_in, adv;
   tga_sd_pkg::result_type p_ff, o_ff, resolved;
   logic [31:0] rdata_ff, run_colour_ff;

   assign adv  = !o_valid_ff || rsp_tready;
   assign take = !p_valid_ff || adv;
   assign p_valid_in = take ? res_valid : p_valid_ff;
   assign o_valid_in = adv ? p_valid_ff : o_valid_ff;

   always_comb begin
      resolved = p_ff;
      if (p_ff.use_run)
         resolved.colour = run_colour_ff;
      else if (p_ff.use_map)
         resolved.colour = p_ff.hit ? rdata_ff : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (wr.en)
         palette[wr.addr[AW-1:0]] <= wr.data;
      if (res_valid && take) begin
         rdata_ff <= palette[res.slot[AW-1:0]];
         p_ff <= res;
      end
      if (adv && p_valid_ff) begin
         o_ff <= resolved;
         if (p_ff.capture)
            run_colour_ff <= resolved.colour;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tuser  = o_ff.status;
   assign rsp_tlast  = o_ff.last;
   assign rsp_tdata  = {7'd0, o_ff.pending, o_ff.colour, o_ff.column, o_ff.row,
                        o_ff.height, o_ff.width};

endmodule

// File: hw/rtl/tga_sd_checker.sv
// Port-level checks on the result channel of the TGA stream decoder.
// Depends on tga_sd_pkg and tga_stream_decoder_top_defines.svh; bound to the top.
`include "tga_stream_decoder_top_defines.svh"

module tga_sd_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic         rsp_tlast,
   input logic [2:0]   rsp_tuser
);

   `TGA_SD_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `TGA_SD_ASSERT_IMPL(a_last_pix, rsp_tvalid && rsp_tlast, rsp_tuser == tga_sd_pkg::ST_PIXEL)
   `TGA_SD_ASSERT_IMPL(a_zero_col, rsp_tvalid && rsp_tuser != tga_sd_pkg::ST_PIXEL, rsp_tdata[95:32] == 64'd0)
   `TGA_SD_ASSERT_IMPL(a_run_byte, rsp_tvalid && rsp_tuser == tga_sd_pkg::ST_RUN_BYTE, rsp_tdata[96])
   `TGA_SD_ASSERT_NEXT_RST(a_reset, reset, !rsp_tvalid)

endmodule

bind tga_stream_decoder_top tga_sd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// File: test/tga_stream_decoder_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for tga_stream_decoder_top: streams TGA files byte by byte (large
// images cut short) and checks every pixel, header and run-byte result against a model.
// Depends on tga_sd_pkg and the block's RTL only.
module tga_stream_decoder_top_test;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int QUIET_LIMIT = 4000;

   typedef struct packed {
      tga_sd_pkg::status_type status;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] row;
      logic [15:0] column;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        last;
      logic        pending;
   } pixel_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data;
   } item_type;

   class tga_decode_board;
      int unsigned mw, mh, fbc, kind, pdep, mpres, mfirst, mlen, mdep, idskip;
      int unsigned wd, ht, attr, part, rleft, rrep, rcol, col, rdone, frow, prow, sub;
      int unsigned pal[256];
      tga_sd_pkg::phase_type ph;
      pixel_type cur;
      pixel_type want_q[$];
      int errors, pixels, headers, faults;

      function new();
         mw = 0;
         mh = 0;
         errors = 0;
         pixels = 0;
         headers = 0;
         faults = 0;
         foreach (pal[i]) pal[i] = 0;
         clear_file();
         ph = tga_sd_pkg::PH_IDLE;
      endfunction

      function void clear_file();
         fbc = 0; kind = 0; pdep = 0; mpres = 0; mfirst = 0; mlen = 0; mdep = 0;
         idskip = 0; wd = 0; ht = 0; attr = 0; part = 0; rleft = 0; rrep = 0;
         rcol = 0; col = 0; rdone = 0; frow = 0; prow = 0; sub = 0;
      endfunction

      function int unsigned colour(int unsigned v, int unsigned d);
         int unsigned j, k, r, g, b;
         j = v & 8'hFF;
         k = (v >> 8) & 8'hFF;
         case (d)
            8: return j | (j << 8) | (j << 16) | (32'hFF << 24);
            15, 16: begin
               r = ((k & 8'h7C) >> 2) << 3;
               g = (((k & 8'h03) << 3) + ((j & 8'hE0) >> 5)) << 3;
               b = (j & 8'h1F) << 3;
               return (r & 8'hFF) | ((g & 8'hFF) << 8) | (b << 16) |
                      (((d == 15 || (k & 8'h80) != 0) ? 32'hFF : 32'h0) << 24);
            end
            24: return ((v >> 16) & 8'hFF) | (k << 8) | (j << 16) | (32'hFF << 24);
            32: return ((v >> 16) & 8'hFF) | (k << 8) | (j << 16) | (v & 32'hFF00_0000);
            default: return 0;
         endcase
      endfunction

      function bit depth_good(int unsigned d);
         return d == 8 || d == 15 || d == 16 || d == 24 || d == 32;
      endfunction

      function bit mapped();
         return mpres != 0 && (kind == 1 || kind == 9);
      endfunction

      function bit rle();
         return kind == 9 || kind == 10 || kind == 11;
      endfunction

      function void enter_body();
         sub = 0;
         part = 0;
         ph = (wd == 0 || ht == 0) ? tga_sd_pkg::PH_DONE : tga_sd_pkg::PH_BODY;
      endfunction

      function void after_id();
         if (mpres != 0 && mlen != 0 && ((mdep + 7) >> 3) != 0) begin
            ph = tga_sd_pkg::PH_MAP;
            fbc = 0;
            sub = 0;
            part = 0;
         end else begin
            enter_body();
         end
      endfunction

      function void base(tga_sd_pkg::status_type st);
         cur = '0;
         cur.status = st;
         cur.width = wd[15:0];
         cur.height = ht[15:0];
      endfunction

      function bit emit(int unsigned c);
         int unsigned r, stp, il;
         base(tga_sd_pkg::ST_PIXEL);
         r = ((attr >> 5) & 1) ? frow : ((ht - frow - 1) & 16'hFFFF);
         cur.row = r[15:0];
         cur.column = col[15:0];
         cur.red = c[7:0];
         cur.green = c[15:8];
         cur.blue = c[23:16];
         cur.alpha = c[31:24];
         cur.last = (rdone + 1 == ht && col + 1 == wd);
         col++;
         if (col >= wd) begin
            col = 0;
            rdone++;
            il = (attr >> 6) & 3;
            stp = (il == 2) ? 4 : (il == 1) ? 2 : 1;
            frow += stp;
            if (frow >= ht) begin
               prow = (prow + 1) & 16'hFFFF;
               frow = prow;
            end
         end
         return rdone >= ht;
      endfunction

      function void finish(bit done);
         if (done) begin
            ph = tga_sd_pkg::PH_DONE;
            rleft = 0;
            rrep = 0;
         end
         cur.pending = (ph == tga_sd_pkg::PH_DRAIN);
         want_q.push_back(cur);
      endfunction

      function void header_byte(int unsigned b);
         tga_sd_pkg::status_type st;
         case (fbc)
            0: idskip = b;
            1: mpres = (b == 1);
            2: kind = b;
            3: mfirst = b;
            4: mfirst |= b << 8;
            5: mlen = b;
            6: mlen |= b << 8;
            7: mdep = b;
            12: wd = b;
            13: wd |= b << 8;
            14: ht = b;
            15: ht |= b << 8;
            16: pdep = b;
            17: attr = b;
            default: ;
         endcase
         fbc++;
         if (fbc < 18) return;
         st = tga_sd_pkg::ST_HEADER_OK;
         if ((mw != 0 && wd != mw) || (mh != 0 && ht != mh))
            st = tga_sd_pkg::ST_SIZE_MISMATCH;
         else if (!(kind inside {1, 2, 3, 9, 10, 11})) st = tga_sd_pkg::ST_BAD_TYPE;
         else if (!depth_good(pdep)) st = tga_sd_pkg::ST_BAD_DEPTH;
         else if (mapped() && !depth_good(mdep)) st = tga_sd_pkg::ST_BAD_MAP_DEPTH;
         else if (mapped() && (mfirst + mlen + 1 >= 16384 || mlen > 256))
            st = tga_sd_pkg::ST_MAP_TOO_BIG;
         base(st);
         want_q.push_back(cur);
         if (st != tga_sd_pkg::ST_HEADER_OK) begin
            ph = tga_sd_pkg::PH_IDLE;
            return;
         end
         fbc = 0;
         if (idskip != 0) ph = tga_sd_pkg::PH_ID;
         else after_id();
      endfunction

      function void map_byte(int unsigned b);
         int unsigned eb;
         eb = (mdep + 7) >> 3;
         if (sub < 4) part |= b << (8 * sub);
         sub++;
         if (sub < eb) return;
         if (mapped() && fbc < 256) pal[fbc] = colour(part, mdep);
         fbc++;
         sub = 0;
         part = 0;
         if (fbc >= mlen) enter_body();
      endfunction

      function void body_byte(int unsigned b);
         int unsigned pb, idx, c;
         pb = (pdep + 7) >> 3;
         if (rle() && rleft == 0) begin
            rrep = (b >> 7) & 1;
            rleft = (b & 8'h7F) + 1;
            sub = 0;
            part = 0;
            return;
         end
         if (sub < 4) part |= b << (8 * sub);
         sub++;
         if (sub < pb) return;
         if (mapped()) begin
            if (pdep == 8) idx = part & 8'hFF;
            else if (pdep == 15 || pdep == 16) idx = part & 16'hFFFF;
            else idx = 0;
            idx = (idx - mfirst) & 16'hFFFF;
            c = (idx < mlen && idx < 256) ? pal[idx] : 0;
         end else begin
            c = colour(part, pdep);
         end
         sub = 0;
         part = 0;
         if (rle() && rleft != 0) rleft--;
         if (rle() && rrep != 0 && rleft != 0) begin
            rcol = c;
            ph = tga_sd_pkg::PH_DRAIN;
         end
         finish(emit(c));
      endfunction

      function void note(logic [1:0] action, logic [7:0] data);
         case (action)
            tga_sd_pkg::ACT_START: begin
               clear_file();
               ph = tga_sd_pkg::PH_HEAD;
            end
            tga_sd_pkg::ACT_DRAIN: begin
               if (ph == tga_sd_pkg::PH_DRAIN) begin
                  if (rleft != 0) rleft--;
                  if (rleft == 0) ph = tga_sd_pkg::PH_BODY;
                  finish(emit(rcol));
               end
            end
            tga_sd_pkg::ACT_BYTE: begin
               case (ph)
                  tga_sd_pkg::PH_HEAD: header_byte(data);
                  tga_sd_pkg::PH_ID: begin
                     fbc++;
                     if (fbc >= idskip) after_id();
                  end
                  tga_sd_pkg::PH_MAP: map_byte(data);
                  tga_sd_pkg::PH_BODY: body_byte(data);
                  tga_sd_pkg::PH_DRAIN: begin
                     base(tga_sd_pkg::ST_RUN_BYTE);
                     cur.pending = 1'b1;
                     want_q.push_back(cur);
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] exp);
         $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, exp);
         errors++;
      endtask

      task check(logic [2:0] status, logic [103:0] data, logic last);
         pixel_type w;
         if (want_q.size() == 0) begin
            report("unexpected result, status", status, 0);
            return;
         end
         w = want_q.pop_front();
         if (w.status == tga_sd_pkg::ST_PIXEL) pixels++;
         else if (w.status == tga_sd_pkg::ST_HEADER_OK) headers++;
         else faults++;
         if (status !== w.status) report("status", status, w.status);
         if (data[15:0] !== w.width) report("hdr width", data[15:0], w.width);
         if (data[31:16] !== w.height) report("hdr height", data[31:16], w.height);
         if (data[47:32] !== w.row) report("row", data[47:32], w.row);
         if (data[63:48] !== w.column) report("column", data[63:48], w.column);
         if (data[71:64] !== w.red) report("red", data[71:64], w.red);
         if (data[79:72] !== w.green) report("green", data[79:72], w.green);
         if (data[87:80] !== w.blue) report("blue", data[87:80], w.blue);
         if (data[95:88] !== w.alpha) report("alpha", data[95:88], w.alpha);
         if (last !== w.last) report("last_pixel", last, w.last);
         if (data[96] !== w.pending) report("run_pending", data[96], w.pending);
         if (data[103:97] !== 7'd0) report("zero fill", data[103:97], 0);
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic [1:0]   req_tuser = ACT_NONE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         rsp_tlast;
   logic [2:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic         csr_index = tga_sd_pkg::CSR_MATCH_WIDTH;
   logic [15:0]  csr_wdata = '0;

   tga_decode_board board = new();
   item_type feed_q[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit hold_req = 1'b0;
   int quiet = 0;
   int files = 0;

   always #2 clock = ~clock;

   tga_stream_decoder_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always @(negedge clock) begin
      if (hold_req && hold_left == 0) begin
         hold_left = 300;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         quiet++;
         if (req_tvalid && req_tready) begin
            board.note(req_tuser, req_tdata);
            quiet = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check(rsp_tuser, rsp_tdata, rsp_tlast);
            quiet = 0;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic put(logic [1:0] a, logic [7:0] d);
      feed_q.push_back('{action: a, data: d});
   endtask

   task automatic put_pixel(bit use_map, int pd, int mfirst, int mlen);
      int unsigned v;
      v = $urandom;
      if (use_map && (pd == 8 || pd == 15 || pd == 16) && $urandom_range(7) != 0)
         v = mfirst + $urandom_range(0, mlen > 0 ? mlen - 1 : 0);
      for (int i = 0; i < (pd + 7) / 8; i++) put(tga_sd_pkg::ACT_BYTE, v[8*i +: 8]);
   endtask

   task automatic gen_file(int w, int h, int kind, int pd, int mtype, int mfirst, int mlen,
                           int md, int idl, int attr, bit overrun);
      int left, n;
      longint area;
      bit rep, use_map;
      use_map = (mtype == 1) && (kind == 1 || kind == 9);
      files++;
      put(tga_sd_pkg::ACT_START, 8'($urandom));
      put(tga_sd_pkg::ACT_BYTE, idl[7:0]);
      put(tga_sd_pkg::ACT_BYTE, mtype[7:0]);
      put(tga_sd_pkg::ACT_BYTE, kind[7:0]);
      put(tga_sd_pkg::ACT_BYTE, mfirst[7:0]);
      put(tga_sd_pkg::ACT_BYTE, mfirst[15:8]);
      put(tga_sd_pkg::ACT_BYTE, mlen[7:0]);
      put(tga_sd_pkg::ACT_BYTE, mlen[15:8]);
      put(tga_sd_pkg::ACT_BYTE, md[7:0]);
      repeat (4) put(tga_sd_pkg::ACT_BYTE, 8'($urandom));
      put(tga_sd_pkg::ACT_BYTE, w[7:0]);
      put(tga_sd_pkg::ACT_BYTE, w[15:8]);
      put(tga_sd_pkg::ACT_BYTE, h[7:0]);
      put(tga_sd_pkg::ACT_BYTE, h[15:8]);
      put(tga_sd_pkg::ACT_BYTE, pd[7:0]);
      put(tga_sd_pkg::ACT_BYTE, attr[7:0]);
      repeat (idl) put(tga_sd_pkg::ACT_BYTE, 8'($urandom));
      if (mtype == 1 && mlen <= 300)
         repeat (mlen * ((md + 7) / 8)) put(tga_sd_pkg::ACT_BYTE, 8'($urandom));
      area = longint'(w) * longint'(h);
      left = (area > 60) ? int'($urandom_range(1, 20)) : int'(area);
      if (kind == 9 || kind == 10 || kind == 11) begin
         while (left > 0) begin
            n = $urandom_range(1, left < 128 ? left : 128);
            if (overrun && n == left) n = (left + 3 < 128) ? left + 3 : 128;
            if ($urandom_range(15) == 0) n = 128;
            rep = 1'($urandom_range(1));
            put(tga_sd_pkg::ACT_BYTE, {rep, 7'(n - 1)});
            if (rep) begin
               put_pixel(use_map, pd, mfirst, mlen);
               repeat (n - 1) begin
                  if ($urandom_range(19) == 0) put(tga_sd_pkg::ACT_BYTE, 8'($urandom));
                  put(tga_sd_pkg::ACT_DRAIN, 8'($urandom));
               end
            end else begin
               repeat (n) put_pixel(use_map, pd, mfirst, mlen);
            end
            left -= n;
            if ($urandom_range(29) == 0) put(ACT_NONE, 8'($urandom));
         end
      end else begin
         repeat (left) put_pixel(use_map, pd, mfirst, mlen);
         if (overrun) put(tga_sd_pkg::ACT_DRAIN, 8'($urandom));
      end
   endtask

   task automatic rand_file();
      int kinds[6] = '{1, 2, 3, 9, 10, 11};
      int depths[5] = '{8, 15, 16, 24, 32};
      int kind, pd, mtype, mfirst, mlen, md, w, h, idl;
      kind = ($urandom_range(24) == 0) ? $urandom_range(255) : kinds[$urandom_range(5)];
      pd = ($urandom_range(24) == 0) ? $urandom_range(255) : depths[$urandom_range(4)];
      md = ($urandom_range(24) == 0) ? $urandom_range(255) : depths[$urandom_range(4)];
      if (kind == 1 || kind == 9) mtype = ($urandom_range(9) == 0) ? 0 : 1;
      else mtype = ($urandom_range(3) == 0) ? $urandom_range(0, 1) : 0;
      if ($urandom_range(19) == 0) mtype = $urandom_range(2, 255);
      mfirst = ($urandom_range(29) == 0) ? 16383 : $urandom_range(0, 12);
      mlen = ($urandom_range(29) == 0) ? 257 : $urandom_range(0, 8);
      if (!board.depth_good(md) && mtype == 1) mlen = 1;
      w = (board.mw != 0) ? board.mw : $urandom_range(0, 6);
      h = (board.mh != 0) ? board.mh : $urandom_range(0, 5);
      if ($urandom_range(19) == 0) w = $urandom_range(0, 65535);
      idl = ($urandom_range(39) == 0) ? 255 : $urandom_range(0, 3);
      gen_file(w, h, kind, pd, mtype, mfirst, mlen, md, idl, $urandom, $urandom_range(4) == 0);
   endtask

   task automatic send_all();
      item_type it;
      while (feed_q.size() > 0) begin
         it = feed_q.pop_front();
         while ($urandom_range(99) < idle_pct) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         @(negedge clock);
         req_tvalid <= 1'b1;
         req_tdata <= it.data;
         req_tuser <= it.action;
         do @(posedge clock); while (!req_tready);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_quiet();
      while (board.want_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == tga_sd_pkg::CSR_MATCH_WIDTH) board.mw = 32'(value);
      else board.mh = 32'(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int idle, int stall, logic [15:0] mw, logic [15:0] mh, int items);
      write_csr(tga_sd_pkg::CSR_MATCH_WIDTH, mw);
      write_csr(tga_sd_pkg::CSR_MATCH_HEIGHT, mh);
      idle_pct = idle;
      stall_pct = stall;
      while (feed_q.size() < items / 2) rand_file();
      send_all();
      wait_quiet();
      while (feed_q.size() < items / 2) rand_file();
      send_all();
      wait_quiet();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // header faults, zero area, the largest image, map limits, interleave and origin
      put(tga_sd_pkg::ACT_DRAIN, 8'h00);
      put(ACT_NONE, 8'hFF);
      gen_file(2, 2, 0, 8, 0, 0, 0, 8, 0, 8'h00, 0);
      gen_file(2, 2, 2, 7, 0, 0, 0, 8, 0, 8'h00, 0);
      gen_file(2, 2, 1, 8, 1, 0, 1, 9, 0, 8'h00, 0);
      gen_file(2, 2, 9, 8, 1, 16383, 1, 24, 0, 8'h00, 0);
      gen_file(2, 2, 1, 8, 1, 0, 257, 24, 0, 8'h00, 0);
      gen_file(0, 3, 2, 24, 0, 0, 0, 8, 1, 8'h20, 0);
      gen_file(65535, 65535, 2, 32, 0, 0, 0, 8, 0, 8'hFF, 0);
      gen_file(3, 4, 9, 16, 1, 2, 4, 15, 2, 8'h40, 1);
      gen_file(2, 5, 11, 8, 0, 0, 0, 8, 0, 8'h80, 1);
      gen_file(3, 3, 1, 8, 1, 0, 3, 32, 0, 8'hC0, 0);
      gen_file(2, 2, 3, 15, 2, 0, 0, 8, 0, 8'h20, 0);
      send_all();
      wait_quiet();

      run_phase(0, 0, 16'd0, 16'd0, 450);
      run_phase(87, 0, 16'd3, 16'd0, 350);
      hold_req = 1'b1;
      run_phase(0, 87, 16'd0, 16'd2, 350);
      hold_req = 1'b0;
      run_phase(17, 17, 16'hFFFF, 16'hFFFF, 200);
      run_phase(0, 0, 16'd1, 16'd1, 300);

      $display("%0d files streamed: %0d pixels, %0d good headers, %0d fault results checked",
               files, board.pixels, board.headers, board.faults);
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// File: tga_stream_decoder_top.f
+incdir+hw/rtl
hw/rtl/tga_sd_pkg.sv
hw/rtl/tga_sd_parse.sv
hw/rtl/tga_sd_out.sv
hw/rtl/tga_stream_decoder_top.sv
hw/rtl/tga_sd_checker.sv
test/tga_stream_decoder_top_test.sv
